### rtl/thc_pkg.sv
// Package for the twelve-hour clock: types, codes and reset constants.
`default_nettype none
package thc_pkg;

  localparam int ElapsedBits = 16;
  localparam int CfgDataW    = 10;
  localparam int CfgIdxW     = 3;

  typedef logic [ElapsedBits-1:0] elapsed_t;

  localparam elapsed_t ElapsedMax = {ElapsedBits{1'b1}};

  localparam logic [7:0] TicksReset     = 8'd18;
  localparam logic [9:0] StopOnKey      = 10'd999;
  localparam logic [4:0] StartHourReset = 5'd12;
  localparam logic [4:0] MidnightHour   = 5'd24;
  localparam logic [4:0] NoonHour       = 5'd12;
  localparam logic [3:0] HourTop        = 4'd12;
  localparam logic [5:0] MinSecTop      = 6'd59;

  typedef enum logic {
    OpStart = 1'b0,
    OpTick  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTicksPerSecond = 3'd0,
    CfgTimeoutSeconds = 3'd1,
    CfgStartHour      = 3'd2,
    CfgStartMinute    = 3'd3,
    CfgStartSecond    = 3'd4
  } cfg_idx_e;

endpackage
`default_nettype wire

### rtl/thc_if.sv
// Valid/ready channel interfaces for the clock's input and result words.
`default_nettype none
interface thc_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic key_hit;

  modport source (output valid, output operation, output key_hit, input ready);
  modport sink   (input valid, input operation, input key_hit, output ready);
endinterface

interface thc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] hour_value;
  logic [5:0] minute_value;
  logic [5:0] second_value;
  logic       is_pm;
  logic [15:0] elapsed_seconds;
  logic       second_passed;
  logic       running;

  modport source (output valid, output hour_value, output minute_value, output second_value,
                  output is_pm, output elapsed_seconds, output second_passed,
                  output running, input ready);
  modport sink   (input valid, input hour_value, input minute_value, input second_value,
                  input is_pm, input elapsed_seconds, input second_passed,
                  input running, output ready);
endinterface
`default_nettype wire

### rtl/twelve_hour_clock_with_timeout.sv
// Top level: twelve-hour time-of-day clock with prescaler and timeout.
//
//   channel | dir | handshake     | word
//   in_i    | in  | valid/ready   | operation, key_hit
//   out_o   | out | valid/ready   | hour, minute, second, pm, elapsed, passed, running
//   cfg     | in  | cfg_we_i only | cfg_index_i, cfg_data_i
//
// One word per cycle while out_o is not stalled: the counter update is a single pass
// of increments and compares from the state registers into the result register.
// Each word shows up on out_o in the cycle after it is accepted.
// in_i.ready is high while the result register is empty or being taken.
// Reset loads the configuration defaults and leaves the clock stopped at 12:00:00 AM.
`default_nettype none
module twelve_hour_clock_with_timeout (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [thc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [thc_pkg::CfgDataW-1:0] cfg_data_i,
  thc_in_if.sink                           in_i,
  thc_out_if.source                        out_o
);

  // Configuration registers.
  logic [7:0] tps_q;
  logic [9:0] timeout_q;
  logic [4:0] start_hour_q;
  logic [5:0] start_minute_q;
  logic [5:0] start_second_q;

  // Clock state.
  logic [7:0]        tick_q, tick_d;
  logic [3:0]        hour_q, hour_d;
  logic [5:0]        minute_q, minute_d;
  logic [5:0]        second_q, second_d;
  logic              pm_q, pm_d;
  thc_pkg::elapsed_t elapsed_q, elapsed_d;
  logic              run_q, run_d;
  logic              passed_d;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  out_hour_q;
  logic [5:0]  out_minute_q;
  logic [5:0]  out_second_q;
  logic        out_pm_q;
  logic [15:0] out_elapsed_q;
  logic        out_passed_q;
  logic        out_run_q;

  logic in_acc;
  logic [thc_pkg::ElapsedBits+15:0] elapsed_wide;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q          <= thc_pkg::TicksReset;
      timeout_q      <= thc_pkg::StopOnKey;
      start_hour_q   <= thc_pkg::StartHourReset;
      start_minute_q <= '0;
      start_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        thc_pkg::CfgTicksPerSecond: tps_q          <= cfg_data_i[7:0];
        thc_pkg::CfgTimeoutSeconds: timeout_q      <= cfg_data_i[9:0];
        thc_pkg::CfgStartHour:      start_hour_q   <= cfg_data_i[4:0];
        thc_pkg::CfgStartMinute:    start_minute_q <= cfg_data_i[5:0];
        thc_pkg::CfgStartSecond:    start_second_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic       pending;
    logic [7:0] tick_inc;
    thc_pkg::elapsed_t timeout_ext;

    tick_d      = tick_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    pm_d        = pm_q;
    elapsed_d   = elapsed_q;
    run_d       = run_q;
    passed_d    = 1'b0;
    pending     = 1'b0;
    tick_inc    = tick_q + 8'd1;
    timeout_ext = thc_pkg::ElapsedBits'(timeout_q);

    if (in_i.operation == thc_pkg::OpStart) begin
      // Convert the 24-hour start hour; zero and 24 both mean midnight.
      pm_d = 1'b0;
      if (start_hour_q == 5'd0 || start_hour_q == thc_pkg::MidnightHour) begin
        hour_d = thc_pkg::HourTop;
      end else if (start_hour_q > thc_pkg::MidnightHour) begin
        hour_d = 4'(start_hour_q - thc_pkg::MidnightHour);
      end else if (start_hour_q >= thc_pkg::NoonHour) begin
        pm_d   = 1'b1;
        hour_d = (start_hour_q == thc_pkg::NoonHour) ? thc_pkg::HourTop
                                                     : 4'(start_hour_q - thc_pkg::NoonHour);
      end else begin
        hour_d = start_hour_q[3:0];
      end
      minute_d  = (start_minute_q > thc_pkg::MinSecTop) ? thc_pkg::MinSecTop : start_minute_q;
      second_d  = (start_second_q > thc_pkg::MinSecTop) ? thc_pkg::MinSecTop : start_second_q;
      tick_d    = '0;
      elapsed_d = '0;
      run_d     = (timeout_q != 10'd0);
    end else if (run_q) begin
      tick_d = tick_inc;
      if (tick_inc >= tps_q) begin
        tick_d  = '0;
        pending = 1'b1;
      end
      // A key stops the clock but still lets an expiring second count;
      // an already reached timeout stops it and drops the second.
      if (timeout_q == thc_pkg::StopOnKey) begin
        if (in_i.key_hit) begin
          run_d = 1'b0;
        end
      end else if (elapsed_q >= timeout_ext) begin
        run_d   = 1'b0;
        pending = 1'b0;
      end
      if (pending) begin
        passed_d = 1'b1;
        if (second_q >= thc_pkg::MinSecTop) begin
          second_d = '0;
          if (minute_q >= thc_pkg::MinSecTop) begin
            minute_d = '0;
            hour_d   = (hour_q >= thc_pkg::HourTop) ? 4'd1 : hour_q + 4'd1;
            if (hour_q == thc_pkg::HourTop - 4'd1) begin
              pm_d = !pm_q;
            end
          end else begin
            minute_d = minute_q + 6'd1;
          end
        end else begin
          second_d = second_q + 6'd1;
        end
        if (elapsed_q != thc_pkg::ElapsedMax) begin
          elapsed_d = elapsed_q + thc_pkg::ElapsedBits'(1);
        end
        if (timeout_q != thc_pkg::StopOnKey && elapsed_d >= timeout_ext) begin
          run_d = 1'b0;
        end
      end
    end
  end

  assign elapsed_wide = {16'd0, elapsed_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      hour_q      <= thc_pkg::HourTop;
      minute_q    <= '0;
      second_q    <= '0;
      pm_q        <= 1'b0;
      elapsed_q   <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_q    <= tick_d;
        hour_q    <= hour_d;
        minute_q  <= minute_d;
        second_q  <= second_d;
        pm_q      <= pm_d;
        elapsed_q <= elapsed_d;
        run_q     <= run_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_hour_q    <= hour_d;
      out_minute_q  <= minute_d;
      out_second_q  <= second_d;
      out_pm_q      <= pm_d;
      out_elapsed_q <= elapsed_wide[15:0];
      out_passed_q  <= passed_d;
      out_run_q     <= run_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.hour_value      = out_hour_q;
  assign out_o.minute_value    = out_minute_q;
  assign out_o.second_value    = out_second_q;
  assign out_o.is_pm           = out_pm_q;
  assign out_o.elapsed_seconds = out_elapsed_q;
  assign out_o.second_passed   = out_passed_q;
  assign out_o.running         = out_run_q;

`ifndef SYNTHESIS
  a_start_no_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.operation == thc_pkg::OpStart |=> out_o.valid && !out_o.second_passed)
    else $error("start word reported a passed second");

  a_stopped_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.operation == thc_pkg::OpTick && !run_q |=>
      !out_o.second_passed && $stable(hour_q) && $stable(second_q) && $stable(elapsed_q))
    else $error("stopped clock advanced");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hour_q != 4'd0 && hour_q <= thc_pkg::HourTop)
    else $error("hour out of range");

  a_min_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minute_q <= thc_pkg::MinSecTop && second_q <= thc_pkg::MinSecTop)
    else $error("minute or second out of range");

  // A tick or a start with a zero timeout can stop a running clock.
  a_stop_on_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run_q) |-> $past(in_acc))
    else $error("clock stopped without an accepted word");
`endif

endmodule
`default_nettype wire

### test/thc_checker.sv
// Watches the clock's channels and register writes, predicts every result word and compares.
`timescale 1ns / 100ps
module thc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [thc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thc_pkg::CfgDataW-1:0] cfg_data_i,
  thc_in_if                            in_w,
  thc_out_if                           out_w,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           seconds_o
);

  typedef struct packed {
    logic [3:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        pm;
    logic [15:0] elapsed;
    logic        passed;
    logic        running;
  } clock_word_t;

  // Shadow copy of the registers.
  logic [7:0] tps_q;
  logic [9:0] timeout_q;
  logic [4:0] start_hour_q;
  logic [5:0] start_min_q;
  logic [5:0] start_sec_q;

  // Shadow copy of the time-keeping state.
  logic [7:0]        tick_q;
  logic [3:0]        hour_q;
  logic [5:0]        min_q;
  logic [5:0]        sec_q;
  logic              pm_q;
  thc_pkg::elapsed_t elapsed_q;
  logic              run_q;

  clock_word_t predicted_times[$];
  int          fails;
  int          checked;
  int          seconds;

  function automatic void count_one_second();
    sec_q = sec_q + 6'd1;
    if (sec_q > thc_pkg::MinSecTop) begin
      sec_q = '0;
      min_q = min_q + 6'd1;
      if (min_q > thc_pkg::MinSecTop) begin
        min_q  = '0;
        hour_q = hour_q + 4'd1;
        if (hour_q > thc_pkg::HourTop) hour_q = 4'd1;
        if (hour_q == thc_pkg::HourTop) pm_q = ~pm_q;
      end
    end
    if (elapsed_q < thc_pkg::ElapsedMax) begin
      elapsed_q = elapsed_q + thc_pkg::ElapsedBits'(1);
    end
  endfunction

  function automatic void load_start_time();
    logic [4:0] h;
    h    = start_hour_q;
    pm_q = 1'b0;
    if (h == 5'd0 || h == thc_pkg::MidnightHour) begin
      h = thc_pkg::NoonHour;
    end else if (h > thc_pkg::MidnightHour) begin
      h = h - thc_pkg::MidnightHour;
    end else if (h >= thc_pkg::NoonHour) begin
      pm_q = 1'b1;
      if (h != thc_pkg::NoonHour) h = h - thc_pkg::NoonHour;
    end
    hour_q    = h[3:0];
    min_q     = (start_min_q > thc_pkg::MinSecTop) ? thc_pkg::MinSecTop : start_min_q;
    sec_q     = (start_sec_q > thc_pkg::MinSecTop) ? thc_pkg::MinSecTop : start_sec_q;
    tick_q    = '0;
    elapsed_q = '0;
    run_q     = (timeout_q != '0);
  endfunction

  function automatic clock_word_t clock_after_word(thc_pkg::op_e op, logic key);
    clock_word_t w;
    logic        due;
    logic        passed;
    passed = 1'b0;
    if (op == thc_pkg::OpStart) begin
      load_start_time();
    end else if (run_q) begin
      due    = 1'b0;
      tick_q = tick_q + 8'd1;
      if (tick_q >= tps_q) begin
        tick_q = '0;
        due    = 1'b1;
      end
      if (timeout_q == thc_pkg::StopOnKey) begin
        if (key) run_q = 1'b0;
      end else if (elapsed_q >= thc_pkg::elapsed_t'(timeout_q)) begin
        // Already at the timeout: stop without counting the expired second.
        run_q = 1'b0;
        due   = 1'b0;
      end
      if (due) begin
        count_one_second();
        passed = 1'b1;
        if (timeout_q != thc_pkg::StopOnKey && elapsed_q >= thc_pkg::elapsed_t'(timeout_q)) begin
          run_q = 1'b0;
        end
      end
    end
    w.hour    = hour_q;
    w.minute  = min_q;
    w.second  = sec_q;
    w.pm      = pm_q;
    w.elapsed = elapsed_q[15:0];
    w.passed  = passed;
    w.running = run_q;
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    clock_word_t exp;
    clock_word_t got;
    if (!rst_ni) begin
      tps_q        = thc_pkg::TicksReset;
      timeout_q    = thc_pkg::StopOnKey;
      start_hour_q = thc_pkg::StartHourReset;
      start_min_q  = '0;
      start_sec_q  = '0;
      tick_q       = '0;
      hour_q       = thc_pkg::HourTop;
      min_q        = '0;
      sec_q        = '0;
      pm_q         = 1'b0;
      elapsed_q    = '0;
      run_q        = 1'b0;
      predicted_times.delete();
      fails        = 0;
      checked      = 0;
      seconds      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          thc_pkg::CfgTicksPerSecond: tps_q        = cfg_data_i[7:0];
          thc_pkg::CfgTimeoutSeconds: timeout_q    = cfg_data_i[9:0];
          thc_pkg::CfgStartHour:      start_hour_q = cfg_data_i[4:0];
          thc_pkg::CfgStartMinute:    start_min_q  = cfg_data_i[5:0];
          thc_pkg::CfgStartSecond:    start_sec_q  = cfg_data_i[5:0];
          default: ;
        endcase
      end
      // A result word always belongs to an earlier input word, so compare first.
      if (out_w.valid && out_w.ready) begin
        if (predicted_times.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          fails++;
        end else begin
          exp = predicted_times.pop_front();
          got.hour    = out_w.hour_value;
          got.minute  = out_w.minute_value;
          got.second  = out_w.second_value;
          got.pm      = out_w.is_pm;
          got.elapsed = out_w.elapsed_seconds;
          got.passed  = out_w.second_passed;
          got.running = out_w.running;
          check_field("hour_value", 32'(exp.hour), 32'(got.hour));
          check_field("minute_value", 32'(exp.minute), 32'(got.minute));
          check_field("second_value", 32'(exp.second), 32'(got.second));
          check_field("is_pm", 32'(exp.pm), 32'(got.pm));
          check_field("elapsed_seconds", 32'(exp.elapsed), 32'(got.elapsed));
          check_field("second_passed", 32'(exp.passed), 32'(got.passed));
          check_field("running", 32'(exp.running), 32'(got.running));
          checked++;
        end
      end
      if (in_w.valid && in_w.ready) begin
        exp = clock_after_word(thc_pkg::op_e'(in_w.operation), in_w.key_hit);
        if (exp.passed) seconds++;
        predicted_times.push_back(exp);
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_times.size();
    checked_o    <= checked;
    seconds_o    <= seconds;
  end

endmodule

### test/twelve_hour_clock_with_timeout_test.sv
// Testbench top for the twelve-hour clock: stimulus, register setup, flow control and verdict.
`timescale 1ns / 100ps
module twelve_hour_clock_with_timeout_test;

  localparam int RandomTarget  = 1880;
  localparam int HoldOffAt     = 600;
  localparam int HoldOffCycles = 300;
  localparam int QuietLimit    = 4000;
  localparam logic [thc_pkg::CfgIdxW-1:0] CfgFirstUnused = 3'd5;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [thc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [thc_pkg::CfgDataW-1:0] cfg_data;

  thc_in_if  in_w();
  thc_out_if out_w();

  int fail_count;
  int predicted_left;
  int words_checked;
  int seconds_counted;

  int words_sent;
  int taken_words;
  int settings_used;
  int quiet_cycles;
  bit steady_feed;
  logic [thc_pkg::CfgDataW-1:0] timeout_set;

  twelve_hour_clock_with_timeout dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_w),
    .out_o       (out_w)
  );

  thc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_w         (in_w),
    .out_w        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (predicted_left),
    .checked_o    (words_checked),
    .seconds_o    (seconds_counted)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic send_word(thc_pkg::op_e op, logic key);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.operation <= op;
    in_w.key_hit   <= key;
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
  endtask

  // Stop offering and let every predicted word come back.
  task automatic drain();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (predicted_left != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [thc_pkg::CfgIdxW-1:0] idx, logic [thc_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    if (idx == thc_pkg::CfgTimeoutSeconds) timeout_set = data;
  endtask

  task automatic finish_writes();
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic random_config();
    logic [thc_pkg::CfgDataW-1:0] tps;
    logic [thc_pkg::CfgDataW-1:0] tmo;
    logic [thc_pkg::CfgDataW-1:0] hr;
    logic [thc_pkg::CfgDataW-1:0] mn;
    logic [thc_pkg::CfgDataW-1:0] sc;
    case ($urandom_range(0, 9))
      0:             tps = '0;
      1, 2, 3, 4, 5: tps = thc_pkg::CfgDataW'($urandom_range(1, 4));
      6, 7:          tps = thc_pkg::CfgDataW'($urandom_range(5, 30));
      8:             tps = 10'd255;
      default:       tps = thc_pkg::CfgDataW'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 9))
      0:          tmo = '0;
      1, 2, 3:    tmo = thc_pkg::StopOnKey;
      4, 5, 6:    tmo = thc_pkg::CfgDataW'($urandom_range(1, 40));
      7:          tmo = 10'd1023;
      8:          tmo = thc_pkg::CfgDataW'($urandom_range(990, 1010));
      default:    tmo = thc_pkg::CfgDataW'($urandom_range(0, 1023));
    endcase
    hr = thc_pkg::CfgDataW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 31));
    mn = thc_pkg::CfgDataW'(($urandom_range(0, 1) == 0) ? $urandom_range(55, 63)
                                                         : $urandom_range(0, 63));
    sc = thc_pkg::CfgDataW'(($urandom_range(0, 1) == 0) ? $urandom_range(55, 63)
                                                         : $urandom_range(0, 63));
    if ($urandom_range(0, 7) == 0) mn = thc_pkg::CfgDataW'($urandom_range(0, 1023));
    if ($urandom_range(0, 7) == 0) sc = thc_pkg::CfgDataW'($urandom_range(0, 1023));
    write_reg(thc_pkg::CfgTicksPerSecond, tps);
    write_reg(thc_pkg::CfgTimeoutSeconds, tmo);
    write_reg(thc_pkg::CfgStartHour, hr);
    write_reg(thc_pkg::CfgStartMinute, mn);
    write_reg(thc_pkg::CfgStartSecond, sc);
    if ($urandom_range(0, 4) == 0)
      write_reg(CfgFirstUnused + thc_pkg::CfgIdxW'($urandom_range(0, 2)),
                thc_pkg::CfgDataW'($urandom_range(0, 1023)));
    finish_writes();
  endtask

  // One setting, then mostly a start followed by ticks; some phases are pure noise
  // and begin without a start, so a clock left running meets the new setting.
  task automatic random_phase();
    int  n;
    bit  noise;
    int  key_odds;
    random_config();
    noise       = ($urandom_range(0, 5) == 0);
    n           = $urandom_range(10, 90);
    steady_feed = ($urandom_range(0, 3) == 0);
    key_odds    = (timeout_set == thc_pkg::StopOnKey) ? 30 : 3;
    if (!noise) send_word(thc_pkg::OpStart, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      if (noise) begin
        send_word(thc_pkg::op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 49) == 0) begin
        send_word(thc_pkg::OpStart, 1'($urandom_range(0, 1)));
      end else begin
        send_word(thc_pkg::OpTick, $urandom_range(0, key_odds) == 0);
      end
    end
    drain();
  endtask

  // Result side: random stalls, steady stretches, and one long hold-off.
  initial begin
    int gap;
    bit steady;
    steady = 1'b0;
    out_w.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken_words % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_w.ready <= 1'b1;
      do @(posedge clk_i); while (!out_w.valid);
      taken_words++;
      if (taken_words == HoldOffAt) begin
        out_w.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles.", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= thc_pkg::CfgTicksPerSecond;
    cfg_data       <= '0;
    in_w.valid     <= 1'b0;
    in_w.operation <= thc_pkg::OpTick;
    in_w.key_hit   <= 1'b0;
    words_sent     = 0;
    taken_words    = 0;
    settings_used  = 0;
    quiet_cycles   = 0;
    steady_feed    = 1'b0;
    timeout_set    = thc_pkg::StopOnKey;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Stopped after reset: ticks change nothing. Then start with the reset settings.
    send_word(thc_pkg::OpTick, 1'b0);
    send_word(thc_pkg::OpTick, 1'b1);
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    send_word(thc_pkg::OpTick, 1'b1);
    send_word(thc_pkg::OpTick, 1'b0);
    drain();

    // One tick per second, 11:59:58 PM rolls over to midnight.
    write_reg(thc_pkg::CfgTicksPerSecond, 10'd1);
    write_reg(thc_pkg::CfgTimeoutSeconds, thc_pkg::StopOnKey);
    write_reg(thc_pkg::CfgStartHour, 10'd23);
    write_reg(thc_pkg::CfgStartMinute, 10'd59);
    write_reg(thc_pkg::CfgStartSecond, 10'd58);
    finish_writes();
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    drain();
    // The clock is still running past a smaller timeout: it stops without counting.
    write_reg(thc_pkg::CfgTimeoutSeconds, 10'd1);
    finish_writes();
    send_word(thc_pkg::OpTick, 1'b0);
    drain();
    // A key press at 11:59:59 AM stops the clock but the second still rolls into noon.
    write_reg(thc_pkg::CfgTimeoutSeconds, thc_pkg::StopOnKey);
    write_reg(thc_pkg::CfgStartHour, 10'd11);
    write_reg(thc_pkg::CfgStartSecond, 10'd59);
    finish_writes();
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b1);
    send_word(thc_pkg::OpTick, 1'b0);
    drain();

    // Zero timeout keeps the clock stopped; hour zero means midnight; every tick a second.
    write_reg(thc_pkg::CfgTicksPerSecond, 10'd0);
    write_reg(thc_pkg::CfgTimeoutSeconds, 10'd0);
    write_reg(thc_pkg::CfgStartHour, 10'd0);
    finish_writes();
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    drain();

    // Hour above 24, minute and second above 59, timeout of two, unused index.
    write_reg(thc_pkg::CfgTimeoutSeconds, 10'd2);
    write_reg(thc_pkg::CfgStartHour, 10'd31);
    write_reg(thc_pkg::CfgStartMinute, 10'd63);
    write_reg(thc_pkg::CfgStartSecond, 10'd63);
    write_reg(CfgFirstUnused + thc_pkg::CfgIdxW'(2), 10'h3FF);
    finish_writes();
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    send_word(thc_pkg::OpTick, 1'b0);
    drain();

    // Slowest prescaler, largest timeout, hour 24; key presses are ignored here.
    write_reg(thc_pkg::CfgTicksPerSecond, 10'd255);
    write_reg(thc_pkg::CfgTimeoutSeconds, 10'd1023);
    write_reg(thc_pkg::CfgStartHour, 10'd24);
    write_reg(thc_pkg::CfgStartMinute, 10'd0);
    write_reg(thc_pkg::CfgStartSecond, 10'd0);
    finish_writes();
    send_word(thc_pkg::OpStart, 1'b0);
    send_word(thc_pkg::OpTick, 1'b1);
    send_word(thc_pkg::OpTick, 1'b1);
    send_word(thc_pkg::OpStart, 1'b1);
    drain();

    while (words_sent < RandomTarget) random_phase();
    drain();

    $display("Checked %0d result words over %0d register settings; %0d clock seconds counted.",
             words_checked, settings_used, seconds_counted);
    $display("Covered start-time conversion, carries, both timeout modes and long back-pressure.");
    if (fail_count == 0 && predicted_left == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/thc_pkg.sv
rtl/thc_if.sv
rtl/twelve_hour_clock_with_timeout.sv
test/thc_checker.sv
test/twelve_hour_clock_with_timeout_test.sv
